// ----- hdl/tmmq_pkg.sv -----
// ----------------------------------------------------------------------------
// tmmq_pkg
// Shared constants and types for the tagged mailbox match queue.
// ----------------------------------------------------------------------------
`default_nettype none
package tmmq_pkg;
    localparam int DEPTH = 1024;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int ENTRY_W = 56;

    typedef enum logic [1:0] {
        CMD_SEND = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_CHECK_INIT = 2'd2,
        CMD_RECV = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_NO_MATCH = 2'd1,
        ST_FULL = 2'd2,
        ST_INACTIVE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

// ----- hdl/tmmq_ram.sv -----
// ----------------------------------------------------------------------------
// tmmq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module tmmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/tagged_mailbox_match_queue.sv -----
// A send is answered directly from idle; check and receive scan the entries in
// order, and a receive then moves each later entry toward the front, reading and
// writing it back through the separate read and write ports of the entry RAM. One transaction
// at a time: no new command is taken until the reply is handed off. Synchronous
// active-low reset empties the inbox, sets the channel counter to one and the owner to active.
// ----------------------------------------------------------------------------
// tagged_mailbox_match_queue
// Message inbox with sender/channel matching and compacting removal.
// ----------------------------------------------------------------------------
`default_nettype none
module tagged_mailbox_match_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[1:0], sender_id[9:2], channel[24:10], payload[56:25], sender_alive[57]
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], channel_out[16:2], sender_out[24:17], payload_out[56:25],
    // is_initiating[57]
    output logic      [63:0] m_tdata
);
    localparam int AW = tmmq_pkg::AW;
    localparam int CW = tmmq_pkg::CW;

    tmmq_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [14:0] nch_reg;
    logic active_reg;
    logic [1:0] cmd_reg;
    logic [7:0] snd_reg;
    logic [14:0] ch_reg;
    logic [AW-1:0] idx_reg;
    logic rd_pend_reg;
    logic [63:0] out_reg;
    logic outv_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [55:0] wdata, rdata;

    tmmq_ram #(.WIDTH(tmmq_pkg::ENTRY_W), .DEPTH(tmmq_pkg::DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // entry: sender[7:0], channel[22:8], init[23], payload[55:24]
    logic hit;
    always_comb begin
        if (cmd_reg == tmmq_pkg::CMD_CHECK_INIT) hit = rdata[23];
        else hit = (snd_reg == 8'd0 || rdata[7:0] == snd_reg) &&
                   (ch_reg == 15'd0 || rdata[22:8] == ch_reg);
    end

    assign s_tready = (state_reg == tmmq_pkg::S_IDLE) && !outv_reg;
    assign m_tvalid = outv_reg;
    assign m_tdata = out_reg;

    logic acc;
    logic [1:0] in_cmd;
    logic [7:0] in_snd;
    logic [14:0] in_ch;
    assign acc = s_tvalid && s_tready;
    assign in_cmd = s_tdata[1:0];
    assign in_snd = s_tdata[9:2];
    assign in_ch = s_tdata[24:10];

    logic last_idx;
    assign last_idx = ({{(CW-AW){1'b0}}, idx_reg} + 1'b1) >= count_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tmmq_pkg::S_IDLE:
                if (acc && in_cmd != tmmq_pkg::CMD_SEND &&
                    !(in_cmd == tmmq_pkg::CMD_RECV && in_snd != 8'd0 && !s_tdata[57]))
                    state_next = (count_reg == '0) ? tmmq_pkg::S_OUT : tmmq_pkg::S_SCAN;
            tmmq_pkg::S_SCAN:
                if (rd_pend_reg) begin
                    if (hit) state_next = (cmd_reg == tmmq_pkg::CMD_RECV && !last_idx)
                        ? tmmq_pkg::S_SHIFT_RD : tmmq_pkg::S_OUT;
                    else if (last_idx) state_next = tmmq_pkg::S_OUT;
                end
            tmmq_pkg::S_SHIFT_RD: state_next = tmmq_pkg::S_SHIFT_WR;
            // count already holds the reduced total here
            tmmq_pkg::S_SHIFT_WR:
                if (last_idx)
                    state_next = tmmq_pkg::S_OUT;
                else state_next = tmmq_pkg::S_SHIFT_RD;
            tmmq_pkg::S_OUT: state_next = tmmq_pkg::S_IDLE;
            default: state_next = tmmq_pkg::S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        we = 1'b0;
        waddr = idx_reg;
        wdata = rdata;
        raddr = idx_reg;
        if (acc && in_cmd == tmmq_pkg::CMD_SEND && active_reg &&
            count_reg < CW'(tmmq_pkg::DEPTH)) begin
            we = 1'b1;
            waddr = count_reg[AW-1:0];
            wdata = {s_tdata[56:25], (in_ch == 15'd0), (in_ch == 15'd0) ? nch_reg : in_ch,
                     in_snd};
        end
        if (state_reg == tmmq_pkg::S_IDLE) raddr = '0;
        else if (state_reg == tmmq_pkg::S_SCAN) raddr = idx_reg + (rd_pend_reg ? 1'b1 : 1'b0);
        else if (state_reg == tmmq_pkg::S_SHIFT_RD) raddr = idx_reg + 1'b1;
        if (state_reg == tmmq_pkg::S_SHIFT_WR) we = 1'b1;
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tmmq_pkg::S_IDLE;
            count_reg <= '0;
            nch_reg <= 15'd1;
            active_reg <= 1'b1;
            outv_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) active_reg <= cfg_wdata;
            if (outv_reg && m_tready) outv_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            unique case (state_reg)
                tmmq_pkg::S_IDLE: if (acc) begin
                    cmd_reg <= in_cmd;
                    snd_reg <= in_snd;
                    ch_reg <= in_ch;
                    idx_reg <= '0;
                    out_reg <= 64'(tmmq_pkg::ST_NO_MATCH);
                    rd_pend_reg <= 1'b1;
                    if (in_cmd == tmmq_pkg::CMD_SEND) begin
                        outv_reg <= 1'b1;
                        if (!active_reg) out_reg <= 64'(tmmq_pkg::ST_INACTIVE);
                        else if (count_reg >= CW'(tmmq_pkg::DEPTH))
                            out_reg <= 64'(tmmq_pkg::ST_FULL);
                        else begin
                            count_reg <= count_reg + 1'b1;
                            if (in_ch == 15'd0) begin
                                out_reg <= {6'd0, 1'b1, 40'd0, nch_reg, tmmq_pkg::ST_OK};
                                nch_reg <= (nch_reg == 15'h7FFF) ? 15'd1 : nch_reg + 1'b1;
                            end else out_reg <= {47'd0, in_ch, tmmq_pkg::ST_OK};
                        end
                    end else if (in_cmd == tmmq_pkg::CMD_RECV && in_snd != 8'd0 &&
                                 !s_tdata[57]) begin
                        outv_reg <= 1'b1;
                        out_reg <= 64'(tmmq_pkg::ST_INACTIVE);
                    end
                end
                tmmq_pkg::S_SCAN: if (rd_pend_reg) begin
                    if (hit) begin
                        out_reg <= {6'd0, rdata[23], rdata[55:24], rdata[7:0], rdata[22:8],
                                    tmmq_pkg::ST_OK};
                        if (cmd_reg == tmmq_pkg::CMD_RECV) count_reg <= count_reg - 1'b1;
                    end else if (!last_idx) begin
                        idx_reg <= idx_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                end else rd_pend_reg <= 1'b1;
                tmmq_pkg::S_SHIFT_RD: ;
                tmmq_pkg::S_SHIFT_WR: idx_reg <= idx_reg + 1'b1;
                tmmq_pkg::S_OUT: outv_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // the inbox never overfills
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(tmmq_pkg::DEPTH))
        else $error("entry count beyond depth");
    // channel counter never zero
    a_nch: assert property (@(posedge aclk) disable iff (!aresetn) nch_reg != 15'd0)
        else $error("channel counter zero");
    // no new transaction while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn) outv_reg |-> !s_tready)
        else $error("accept while result pending");
endmodule
`default_nettype wire

// ----- test/tb_tagged_mailbox_match_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tagged_mailbox_match_queue
// Self-checking bench for the mailbox inbox: a behavioural inbox model
// predicts each reply. Directed commands first, then random traffic in
// phases with different owner settings and handshake idling.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_tagged_mailbox_match_queue;

    typedef struct packed {
        logic [7:0]  sender;
        logic [14:0] chan;
        logic        init;
        logic [31:0] payload;
    } msg_t;

    typedef struct packed {
        tmmq_pkg::status_t status;
        logic [14:0] chan;
        logic [7:0]  sender;
        logic [31:0] payload;
        logic        init;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    tagged_mailbox_match_queue DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // inbox model state
    msg_t        inbox[$];
    logic [14:0] chan_counter = 15'd1;
    logic        owner_active = 1'b1;

    logic [63:0] pending_cmds[$];
    reply_t      expected_replies[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off_cycles = 0;
    int          mismatches = 0;
    int          accepted = 0;
    int          replies_seen = 0;
    int          ok_recvs = 0;

    function automatic reply_t predict_reply(logic [63:0] d);
        tmmq_pkg::cmd_t cmd;
        logic [7:0]  sid;
        logic [14:0] ch;
        logic [31:0] pay;
        logic        alive;
        reply_t      r;
        msg_t        m;
        int          hit;
        cmd = tmmq_pkg::cmd_t'(d[1:0]);
        sid = d[9:2];
        ch = d[24:10];
        pay = d[56:25];
        alive = d[57];
        r = '{tmmq_pkg::ST_NO_MATCH, 15'd0, 8'd0, 32'd0, 1'b0};
        hit = -1;
        case (cmd)
            tmmq_pkg::CMD_SEND: begin
                if (!owner_active) begin
                    r.status = tmmq_pkg::ST_INACTIVE;
                end else if (inbox.size() >= tmmq_pkg::DEPTH) begin
                    r.status = tmmq_pkg::ST_FULL;
                end else begin
                    m = '{sid, ch, 1'b0, pay};
                    if (ch == 15'd0) begin
                        m.chan = chan_counter;
                        m.init = 1'b1;
                        chan_counter = (chan_counter == 15'h7fff) ? 15'd1
                                                                  : chan_counter + 15'd1;
                    end
                    inbox.push_back(m);
                    r = '{tmmq_pkg::ST_OK, m.chan, 8'd0, 32'd0, m.init};
                end
            end
            tmmq_pkg::CMD_CHECK_INIT: begin
                foreach (inbox[i])
                    if (hit < 0 && inbox[i].init) hit = i;
            end
            default: begin
                if (cmd == tmmq_pkg::CMD_RECV && sid != 8'd0 && !alive) begin
                    r.status = tmmq_pkg::ST_INACTIVE;
                    return r;
                end
                foreach (inbox[i])
                    if (hit < 0 && (sid == 8'd0 || inbox[i].sender == sid) &&
                        (ch == 15'd0 || inbox[i].chan == ch)) hit = i;
            end
        endcase
        if (hit >= 0) begin
            m = inbox[hit];
            r = '{tmmq_pkg::ST_OK, m.chan, m.sender, m.payload, m.init};
            if (cmd == tmmq_pkg::CMD_RECV) begin
                inbox.delete(hit);
                ok_recvs++;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s at %0t: got %h expected %h", what, $time, got, want);
        mismatches++;
    endtask

    // driver: nonblocking at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(predict_reply(s_tdata));
                accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata <= pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver readiness, with a long hold-off when asked
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected reply", m_tdata, 64'd0);
            end else begin
                want = expected_replies.pop_front();
                if (m_tdata[1:0] != want.status)
                    report_mismatch("status", 64'(m_tdata[1:0]), 64'(want.status));
                if (m_tdata[16:2] != want.chan)
                    report_mismatch("channel_out", 64'(m_tdata[16:2]), 64'(want.chan));
                if (m_tdata[24:17] != want.sender)
                    report_mismatch("sender_out", 64'(m_tdata[24:17]), 64'(want.sender));
                if (m_tdata[56:25] != want.payload)
                    report_mismatch("payload_out", 64'(m_tdata[56:25]), 64'(want.payload));
                if (m_tdata[57] != want.init)
                    report_mismatch("is_initiating", 64'(m_tdata[57]), 64'(want.init));
            end
        end
    end

    function automatic logic [63:0] pack_cmd(tmmq_pkg::cmd_t c, logic [7:0] s,
                                             logic [14:0] ch, logic [31:0] p, logic a);
        return {6'd0, a, p, ch, s, c};
    endfunction

    // wait until all queued commands are answered, then let the block settle
    task automatic drain();
        while (pending_cmds.size() > 0 || s_tvalid || expected_replies.size() > 0)
            @(posedge aclk);
        repeat (3 * tmmq_pkg::DEPTH + 20) @(posedge aclk);
    endtask

    task automatic write_owner(logic v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        owner_active = v;
    endtask

    // mostly well-formed: random sends, checks and receives aimed at held messages
    task automatic queue_random(int n);
        logic [7:0]  s;
        logic [14:0] ch;
        int          pick;
        repeat (n) begin
            pick = $urandom_range(99);
            s = 8'($urandom_range(0, 7));
            ch = $urandom_range(0, 3) == 0 ? 15'd0 : 15'($urandom_range(1, 12));
            if (pick < 8) begin
                s = 8'($urandom);
                ch = 15'($urandom);
            end
            if (pick < 45)
                pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_SEND, s,
                                       $urandom_range(0, 1) ? 15'd0 : ch,
                                       32'($urandom), 1'b1));
            else if (pick < 60)
                pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_CHECK, s, ch,
                                                32'($urandom), 1'($urandom)));
            else if (pick < 68)
                pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_CHECK_INIT, 8'($urandom),
                                                15'($urandom), 32'($urandom),
                                                1'($urandom)));
            else
                pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_RECV, s, ch, 32'($urandom),
                                                $urandom_range(99) < 85));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: each command, field extremes, dead sender, no match
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_RECV, 8'd0, 15'd0, 32'd0, 1'b1));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_CHECK_INIT, 8'hff, 15'h7fff, '1,
                                        1'b1));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_SEND, 8'd0, 15'd0, 32'hffffffff,
                                        1'b0));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_SEND, 8'hff, 15'h7fff, 32'h0, 1'b1));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_SEND, 8'h5a, 15'd0, 32'ha5a5a5a5,
                                        1'b0));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_CHECK, 8'hff, 15'd0, 32'd0, 1'b0));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_CHECK, 8'd0, 15'h7fff, 32'd0, 1'b0));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_CHECK, 8'h11, 15'd3, 32'd0, 1'b0));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_CHECK_INIT, 8'd0, 15'd0, 32'd0,
                                        1'b0));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_RECV, 8'hff, 15'd0, 32'd0, 1'b0));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_RECV, 8'hff, 15'h7fff, 32'd0, 1'b1));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_RECV, 8'd0, 15'd1, 32'd0, 1'b0));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_RECV, 8'h22, 15'd0, 32'd0, 1'b1));
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_CHECK_INIT, 8'd0, 15'd0, 32'd0,
                                        1'b0));
        drain();

        // owner inactive: sends refused, receives still served
        write_owner(1'b0);
        pending_cmds.push_back(pack_cmd(tmmq_pkg::CMD_SEND, 8'h01, 15'd0, 32'h1234, 1'b1));
        queue_random(30);
        drain();
        write_owner(1'b1);

        // random phase one, with a long receiver hold-off to back up the input
        send_idle_pct = 31;
        recv_idle_pct = 70;
        hold_off_cycles = 3000;
        queue_random(90);
        drain();

        send_idle_pct = 70;
        recv_idle_pct = 31;
        queue_random(80);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(80);
        drain();

        $display("covered %0d commands, %0d replies, %0d successful receives",
                 accepted, replies_seen, ok_recvs);
        $display("owner toggled off and on; %0d messages left in inbox", inbox.size());
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #100ms;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
